@@ rtl/ilc_pkg.sv @@
// ----------------------------------------------------------------------------
// ilc_pkg
// Shared widths, codes, register layout and state record of the input level
// calibrator.
// ----------------------------------------------------------------------------
package ilc_pkg;

	localparam int SAMPLE_W    = 16;
	localparam int PEAK_W      = 16;
	localparam int CNT_W       = 25;
	localparam int SUM_W       = 55;
	localparam int POW_W       = 31;
	localparam int BSUM_W      = 41;
	localparam int BLEN_W      = 11;
	localparam int MAX_BLOCK   = 1024;
	localparam int DECAY_MUL   = 210;
	localparam int DECAY_SHIFT = 8;
	localparam int ADDR_W      = 4;
	localparam int DATA_W      = 32;

	typedef enum logic [2:0] {
		PH_IDLE  = 3'd0,
		PH_ROOM  = 3'd1,
		PH_VOICE = 3'd2,
		PH_DONE  = 3'd3,
		PH_FAIL  = 3'd4
	} phase_t;

	typedef enum logic [1:0] {
		CMD_SAMPLE = 2'd0,
		CMD_START  = 2'd1,
		CMD_CANCEL = 2'd2
	} cmd_t;

	typedef enum logic [1:0] {
		REG_ROOM_LEN  = 2'd0,
		REG_VOICE_LEN = 2'd1,
		REG_MIN_POW   = 2'd2,
		REG_MIN_FLOOR = 2'd3
	} reg_idx_t;

	localparam logic [CNT_W-1:0] ROOM_LEN_RST  = CNT_W'(96000);
	localparam logic [CNT_W-1:0] VOICE_LEN_RST = CNT_W'(144000);
	localparam logic [POW_W-1:0] MIN_POW_RST   = POW_W'(9664);
	localparam logic [POW_W-1:0] MIN_FLOOR_RST = POW_W'(38655);

	typedef struct packed {
		logic [CNT_W-1:0] room_len;
		logic [CNT_W-1:0] voice_len;
		logic [POW_W-1:0] min_pow;
		logic [POW_W-1:0] min_floor;
	} cfg_t;

	typedef struct packed {
		phase_t             phase;
		logic [BSUM_W-1:0]  blk_sum;
		logic [BLEN_W-1:0]  blk_len;
		logic [PEAK_W-1:0]  blk_peak;
		logic [PEAK_W-1:0]  in_peak;
		logic [PEAK_W-1:0]  voice_peak;
		logic [CNT_W-1:0]   phase_cnt;
		logic [SUM_W-1:0]   room_sum;
		logic [CNT_W-1:0]   room_cnt;
		logic [SUM_W-1:0]   voice_sum;
		logic [CNT_W-1:0]   voice_cnt;
	} state_t;

	localparam state_t STATE_RESET = '{phase: PH_IDLE, default: '0};

	typedef struct packed {
		logic busy;
		logic done;
		logic ok;
	} dec_status_t;

endpackage

@@ rtl/input_level_calibrator.sv @@
// ----------------------------------------------------------------------------
// input_level_calibrator
// Room tone and voice level measurement over blocks of Q1.15 samples, with
// a pass or fail decision at the end of the voice phase.
// ----------------------------------------------------------------------------
//  channel   handshake                   payload
//  item      item_valid / item_stall     command, sample, last_in_block
//  result    result_valid / result_stall phase, input_peak, voice_peak,
//                                        samples_in_phase, room_*, voice_*
//  config    psel/penable/pwrite/pready  paddr, pwdata, prdata
//
//  One word per cycle unless the decision unit or result_stall holds it.
//  The word that ends the voice phase holds the input
//  while the shared multiplier of the decision unit does the cross products.
//  Reset loads the register defaults and the idle state; no clearing pass.
//  result_stall holds the state registers and backs up into item_stall.
// ----------------------------------------------------------------------------
module input_level_calibrator (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [ilc_pkg::ADDR_W-1:0]   paddr,
	input  logic [ilc_pkg::DATA_W-1:0]   pwdata,
	output logic [ilc_pkg::DATA_W-1:0]   prdata,
	output logic                         pready,
	input  logic                         item_valid,
	output logic                         item_stall,
	input  logic [1:0]                   command,
	input  logic signed [ilc_pkg::SAMPLE_W-1:0] sample,
	input  logic                         last_in_block,
	output logic                         result_valid,
	input  logic                         result_stall,
	output logic [2:0]                   phase,
	output logic [ilc_pkg::PEAK_W-1:0]   input_peak,
	output logic [ilc_pkg::PEAK_W-1:0]   voice_peak,
	output logic [ilc_pkg::CNT_W-1:0]    samples_in_phase,
	output logic [ilc_pkg::SUM_W-1:0]    room_square_sum,
	output logic [ilc_pkg::CNT_W-1:0]    room_count,
	output logic [ilc_pkg::SUM_W-1:0]    voice_square_sum,
	output logic [ilc_pkg::CNT_W-1:0]    voice_count
);
	import ilc_pkg::*;

	cfg_t                 cfg;
	state_t               state_q;
	state_t               nxt;
	dec_status_t          dec;
	logic                 decide;
	logic                 consume;
	logic                 result_valid_q;

	logic                 valid_s1;
	logic [1:0]           cmd_s1;
	logic [SAMPLE_W-1:0]  sample_s1;
	logic                 last_s1;

	ilc_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	ilc_step u_step (
		.cur           (state_q),
		.cfg           (cfg),
		.command       (cmd_s1),
		.sample        (sample_s1),
		.last_in_block (last_s1),
		.nxt           (nxt),
		.decide        (decide)
	);

	ilc_decide u_decide (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (consume && decide),
		.voice_sum (state_q.voice_sum),
		.voice_cnt (state_q.voice_cnt),
		.room_sum  (state_q.room_sum),
		.room_cnt  (state_q.room_cnt),
		.min_pow   (cfg.min_pow),
		.min_floor (cfg.min_floor),
		.stat      (dec)
	);

	// the state registers double as the result register
	assign consume    = valid_s1 && !dec.busy && (!result_valid_q || !result_stall);
	assign item_stall = valid_s1 && !consume;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!item_stall) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && !item_stall) begin
			cmd_s1    <= command;
			sample_s1 <= sample;
			last_s1   <= last_in_block;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= STATE_RESET;
			result_valid_q <= 1'b0;
		end else begin
			if (consume) begin
				state_q <= nxt;
			end else if (dec.done) begin
				state_q.phase <= dec.ok ? PH_DONE : PH_FAIL;
			end
			if ((consume && !decide) || dec.done) begin
				result_valid_q <= 1'b1;
			end else if (!result_stall) begin
				result_valid_q <= 1'b0;
			end
		end
	end

	assign result_valid     = result_valid_q;
	assign phase            = state_q.phase;
	assign input_peak       = state_q.in_peak;
	assign voice_peak       = state_q.voice_peak;
	assign samples_in_phase = state_q.phase_cnt;
	assign room_square_sum  = state_q.room_sum;
	assign room_count       = state_q.room_cnt;
	assign voice_square_sum = state_q.voice_sum;
	assign voice_count      = state_q.voice_cnt;

endmodule

@@ rtl/ilc_regs.sv @@
// ----------------------------------------------------------------------------
// ilc_regs
// APB-style configuration registers: lengths of both phases and the two
// voice power floors.
// ----------------------------------------------------------------------------
module ilc_regs (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [ilc_pkg::ADDR_W-1:0]  paddr,
	input  logic [ilc_pkg::DATA_W-1:0]  pwdata,
	output logic [ilc_pkg::DATA_W-1:0]  prdata,
	output logic                        pready,
	output ilc_pkg::cfg_t               cfg
);
	import ilc_pkg::*;

	reg_idx_t idx;
	cfg_t     cfg_q;

	assign idx    = reg_idx_t'(paddr[ADDR_W-1:2]);
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.room_len  <= ROOM_LEN_RST;
			cfg_q.voice_len <= VOICE_LEN_RST;
			cfg_q.min_pow   <= MIN_POW_RST;
			cfg_q.min_floor <= MIN_FLOOR_RST;
		end else if (psel && penable && pwrite && pready) begin
			unique case (idx)
				REG_ROOM_LEN:  cfg_q.room_len  <= pwdata[CNT_W-1:0];
				REG_VOICE_LEN: cfg_q.voice_len <= pwdata[CNT_W-1:0];
				REG_MIN_POW:   cfg_q.min_pow   <= pwdata[POW_W-1:0];
				REG_MIN_FLOOR: cfg_q.min_floor <= pwdata[POW_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			REG_ROOM_LEN:  prdata = DATA_W'(cfg_q.room_len);
			REG_VOICE_LEN: prdata = DATA_W'(cfg_q.voice_len);
			REG_MIN_POW:   prdata = DATA_W'(cfg_q.min_pow);
			REG_MIN_FLOOR: prdata = DATA_W'(cfg_q.min_floor);
			default:       prdata = '0;
		endcase
	end

endmodule

@@ rtl/ilc_step.sv @@
// ----------------------------------------------------------------------------
// ilc_step
// Next-state logic for one word: block accumulation, block end, phase
// totals and phase changes. Flags the voice phase end for the decision unit.
// ----------------------------------------------------------------------------
module ilc_step (
	input  ilc_pkg::state_t                cur,
	input  ilc_pkg::cfg_t                  cfg,
	input  logic [1:0]                     command,
	input  logic [ilc_pkg::SAMPLE_W-1:0]   sample,
	input  logic                           last_in_block,
	output ilc_pkg::state_t                nxt,
	output logic                           decide
);
	import ilc_pkg::*;

	function automatic logic [SUM_W-1:0] sat_sum(input logic [SUM_W-1:0] a,
			input logic [BSUM_W-1:0] b);
		logic [SUM_W:0] s;
		s = {1'b0, a} + (SUM_W+1)'(b);
		return s[SUM_W] ? '1 : s[SUM_W-1:0];
	endfunction

	function automatic logic [CNT_W-1:0] sat_cnt(input logic [CNT_W-1:0] a,
			input logic [BLEN_W-1:0] b);
		logic [CNT_W:0] s;
		s = {1'b0, a} + (CNT_W+1)'(b);
		return s[CNT_W] ? '1 : s[CNT_W-1:0];
	endfunction

	logic [SAMPLE_W-1:0]               mag;
	logic [2*SAMPLE_W-1:0]             sq;
	logic [BSUM_W-1:0]                 bsum;
	logic [PEAK_W-1:0]                 bpeak;
	logic [BLEN_W-1:0]                 blen;
	logic [PEAK_W+DECAY_SHIFT-1:0]     dprod;
	logic [PEAK_W-1:0]                 decayed;
	logic [CNT_W-1:0]                  cnt;
	logic                              block_end;
	logic                              running;

	always_comb begin
		mag       = sample[SAMPLE_W-1] ? SAMPLE_W'(~sample + 1'b1) : sample;
		sq        = (2*SAMPLE_W)'(mag) * (2*SAMPLE_W)'(mag);
		bsum      = cur.blk_sum + BSUM_W'(sq);
		bpeak     = (mag > cur.blk_peak) ? mag : cur.blk_peak;
		blen      = cur.blk_len + 1'b1;
		block_end = last_in_block || (blen >= BLEN_W'(MAX_BLOCK));
		dprod     = (PEAK_W+DECAY_SHIFT)'(cur.in_peak) * (PEAK_W+DECAY_SHIFT)'(DECAY_MUL);
		decayed   = dprod[PEAK_W+DECAY_SHIFT-1:DECAY_SHIFT];
		cnt       = sat_cnt(cur.phase_cnt, blen);
		running   = (cur.phase == PH_ROOM) || (cur.phase == PH_VOICE);

		nxt    = cur;
		decide = 1'b0;

		unique case (command)
			CMD_START: begin
				nxt       = STATE_RESET;
				nxt.phase = PH_ROOM;
			end
			CMD_CANCEL: begin
				nxt.phase    = PH_IDLE;
				nxt.in_peak  = '0;
				nxt.blk_sum  = '0;
				nxt.blk_len  = '0;
				nxt.blk_peak = '0;
			end
			CMD_SAMPLE: begin
				if (running && !block_end) begin
					nxt.blk_sum  = bsum;
					nxt.blk_peak = bpeak;
					nxt.blk_len  = blen;
				end else if (running) begin
					nxt.in_peak  = (bpeak > decayed) ? bpeak : decayed;
					nxt.blk_sum  = '0;
					nxt.blk_len  = '0;
					nxt.blk_peak = '0;
					if (cur.phase == PH_ROOM) begin
						nxt.room_sum = sat_sum(cur.room_sum, bsum);
						nxt.room_cnt = sat_cnt(cur.room_cnt, blen);
						if (cnt >= cfg.room_len) begin
							nxt.phase_cnt = '0;
							nxt.phase     = PH_VOICE;
						end else begin
							nxt.phase_cnt = cnt;
						end
					end else begin
						nxt.voice_sum = sat_sum(cur.voice_sum, bsum);
						nxt.voice_cnt = sat_cnt(cur.voice_cnt, blen);
						if (bpeak > cur.voice_peak) begin
							nxt.voice_peak = bpeak;
						end
						nxt.phase_cnt = cnt;
						decide        = (cnt >= cfg.voice_len);
					end
				end
			end
			default: ;
		endcase
	end

endmodule

@@ rtl/ilc_decide.sv @@
// ----------------------------------------------------------------------------
// ilc_decide
// Pass or fail decision at voice end. Compares mean squares by cross
// multiplication through one registered 32x25 multiplier.
// ----------------------------------------------------------------------------
module ilc_decide (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [ilc_pkg::SUM_W-1:0]  voice_sum,
	input  logic [ilc_pkg::CNT_W-1:0]  voice_cnt,
	input  logic [ilc_pkg::SUM_W-1:0]  room_sum,
	input  logic [ilc_pkg::CNT_W-1:0]  room_cnt,
	input  logic [ilc_pkg::POW_W-1:0]  min_pow,
	input  logic [ilc_pkg::POW_W-1:0]  min_floor,
	output ilc_pkg::dec_status_t       stat
);
	import ilc_pkg::*;

	localparam int A_W  = 32;
	localparam int P_W  = A_W + CNT_W;
	localparam int R4_W = SUM_W + 2;
	localparam int AA_W = SUM_W + CNT_W;
	localparam int AB_W = R4_W + CNT_W;

	// name = product issued in that cycle; the previous product is taken in
	typedef enum logic [2:0] {
		DS_MIN_POW   = 3'd0,
		DS_MIN_FLOOR = 3'd1,
		DS_VOICE_LO  = 3'd2,
		DS_VOICE_HI  = 3'd3,
		DS_ROOM_LO   = 3'd4,
		DS_ROOM_HI   = 3'd5,
		DS_ROOM_ADD  = 3'd6,
		DS_FINAL     = 3'd7
	} dstep_t;

	dstep_t            step_q;
	logic              busy_q;
	logic [P_W-1:0]    p_q;
	logic [AA_W-1:0]   acc_a_q;
	logic [AB_W-1:0]   acc_b_q;
	logic              ok_pow_q;
	logic              ok_floor_q;

	logic [CNT_W-1:0]  rc;
	logic [CNT_W-1:0]  vc;
	logic [R4_W-1:0]   r4;
	logic [A_W-1:0]    op_a;
	logic [CNT_W-1:0]  op_b;
	logic [P_W-1:0]    prod;

	// empty counts count as one
	assign rc   = (room_cnt == '0) ? CNT_W'(1) : room_cnt;
	assign vc   = (voice_cnt == '0) ? CNT_W'(1) : voice_cnt;
	assign r4   = {room_sum, 2'b00};
	assign prod = P_W'(op_a) * P_W'(op_b);

	always_comb begin
		unique case (step_q)
			DS_MIN_POW: begin
				op_a = A_W'(min_pow);
				op_b = vc;
			end
			DS_MIN_FLOOR: begin
				op_a = A_W'(min_floor);
				op_b = vc;
			end
			DS_VOICE_LO: begin
				op_a = voice_sum[A_W-1:0];
				op_b = rc;
			end
			DS_VOICE_HI: begin
				op_a = A_W'(voice_sum[SUM_W-1:A_W]);
				op_b = rc;
			end
			DS_ROOM_LO: begin
				op_a = r4[A_W-1:0];
				op_b = vc;
			end
			DS_ROOM_HI: begin
				op_a = A_W'(r4[R4_W-1:A_W]);
				op_b = vc;
			end
			default: begin
				op_a = '0;
				op_b = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q     <= 1'b0;
			step_q     <= DS_MIN_POW;
			p_q        <= '0;
			acc_a_q    <= '0;
			acc_b_q    <= '0;
			ok_pow_q   <= 1'b0;
			ok_floor_q <= 1'b0;
		end else begin
			p_q <= prod;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= DS_MIN_POW;
			end else if (busy_q) begin
				step_q <= dstep_t'(step_q + 1'b1);
				if (step_q == DS_FINAL) begin
					busy_q <= 1'b0;
				end
				unique case (step_q)
					DS_MIN_FLOOR: ok_pow_q   <= (P_W'(voice_sum) >= p_q);
					DS_VOICE_LO:  ok_floor_q <= (P_W'(voice_sum) >= p_q);
					DS_VOICE_HI:  acc_a_q    <= AA_W'(p_q);
					DS_ROOM_LO:   acc_a_q    <= acc_a_q + (AA_W'(p_q) << A_W);
					DS_ROOM_HI:   acc_b_q    <= AB_W'(p_q);
					DS_ROOM_ADD:  acc_b_q    <= acc_b_q + (AB_W'(p_q) << A_W);
					default: ;
				endcase
			end
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = busy_q && (step_q == DS_FINAL);
	assign stat.ok   = ok_pow_q && ok_floor_q && (AB_W'(acc_a_q) >= acc_b_q);

endmodule

@@ tb/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for input_level_calibrator. A driver process feeds
// command and sample words from a backlog queue, a predictor tracks the room
// tone and voice totals and the final decision for every word taken, and a
// monitor compares each report with the oldest prediction. Register settings
// change between batches while the block is quiet.
// ----------------------------------------------------------------------------
module testbench;
	import ilc_pkg::*;

	localparam logic [1:0] CMD_NOP       = 2'd3;
	localparam int         CYCLE_LIMIT   = 500000;
	localparam int         QUIET_CYCLES  = 16;
	localparam int         HOLD_AT       = 200;
	localparam int         HOLD_LEN      = 150;
	localparam int         HOLD_BACKLOG  = 8;
	localparam int         LEN_CAP       = 60;
	localparam int         BATCH_WORDS   = 60;
	localparam logic [63:0] SUM_MAX     = (64'd1 << SUM_W) - 64'd1;
	localparam logic [63:0] CNT_MAX     = (64'd1 << CNT_W) - 64'd1;
	localparam logic [63:0] BLK_SUM_MAX = (64'd1 << 48) - 64'd1;
	localparam logic [31:0] LEN_MAX     = 32'd16777216;
	localparam logic [31:0] POW_MAX     = 32'd1073741824;

	typedef struct {
		logic [1:0]                  cmd;
		logic signed [SAMPLE_W-1:0]  smp;
		logic                        last;
	} sample_word_t;

	typedef struct {
		logic [2:0]        phase;
		logic [PEAK_W-1:0] input_peak;
		logic [PEAK_W-1:0] voice_peak;
		logic [CNT_W-1:0]  phase_cnt;
		logic [SUM_W-1:0]  room_sum;
		logic [CNT_W-1:0]  room_cnt;
		logic [SUM_W-1:0]  voice_sum;
		logic [CNT_W-1:0]  voice_cnt;
	} level_report_t;

	logic                        clk;
	logic                        arst_n = 1'b0;
	logic                        psel = 1'b0;
	logic                        penable = 1'b0;
	logic                        pwrite = 1'b0;
	logic [ADDR_W-1:0]           paddr = '0;
	logic [DATA_W-1:0]           pwdata = '0;
	logic [DATA_W-1:0]           prdata;
	logic                        pready;
	logic                        item_valid = 1'b0;
	logic                        item_stall;
	logic [1:0]                  command = CMD_SAMPLE;
	logic signed [SAMPLE_W-1:0]  sample = '0;
	logic                        last_in_block = 1'b0;
	logic                        result_valid;
	logic                        result_stall = 1'b0;
	logic [2:0]                  phase;
	logic [PEAK_W-1:0]           input_peak;
	logic [PEAK_W-1:0]           voice_peak;
	logic [CNT_W-1:0]            samples_in_phase;
	logic [SUM_W-1:0]            room_square_sum;
	logic [CNT_W-1:0]            room_count;
	logic [SUM_W-1:0]            voice_square_sum;
	logic [CNT_W-1:0]            voice_count;

	input_level_calibrator u_top (
		.clk              (clk),
		.arst_n           (arst_n),
		.psel             (psel),
		.penable          (penable),
		.pwrite           (pwrite),
		.paddr            (paddr),
		.pwdata           (pwdata),
		.prdata           (prdata),
		.pready           (pready),
		.item_valid       (item_valid),
		.item_stall       (item_stall),
		.command          (command),
		.sample           (sample),
		.last_in_block    (last_in_block),
		.result_valid     (result_valid),
		.result_stall     (result_stall),
		.phase            (phase),
		.input_peak       (input_peak),
		.voice_peak       (voice_peak),
		.samples_in_phase (samples_in_phase),
		.room_square_sum  (room_square_sum),
		.room_count       (room_count),
		.voice_square_sum (voice_square_sum),
		.voice_count      (voice_count)
	);

	// predictor copy of the registers and state
	logic [CNT_W-1:0]  cfg_room_len  = ROOM_LEN_RST;
	logic [CNT_W-1:0]  cfg_voice_len = VOICE_LEN_RST;
	logic [POW_W-1:0]  cfg_min_pow   = MIN_POW_RST;
	logic [POW_W-1:0]  cfg_min_floor = MIN_FLOOR_RST;

	phase_t            cal_phase  = PH_IDLE;
	logic [47:0]       blk_energy = '0;
	int                blk_len    = 0;
	logic [PEAK_W-1:0] blk_peak   = '0;
	logic [PEAK_W-1:0] in_peak_q  = '0;
	logic [PEAK_W-1:0] spk_peak   = '0;
	logic [CNT_W-1:0]  ph_cnt     = '0;
	logic [SUM_W-1:0]  room_e     = '0;
	logic [CNT_W-1:0]  room_n     = '0;
	logic [SUM_W-1:0]  voice_e    = '0;
	logic [CNT_W-1:0]  voice_n    = '0;

	sample_word_t  word_backlog[$];
	level_report_t pending_reports[$];

	int  words_queued = 0;
	int  words_taken = 0;
	int  reports_seen = 0;
	int  mismatches = 0;
	int  runs_complete = 0;
	int  runs_failed = 0;
	int  send_wait = 0;
	bit  send_calm = 1'b0;
	int  recv_wait = 0;
	bit  recv_calm = 1'b0;
	int  hold_left = 0;
	bit  hold_used = 1'b0;
	int  cycles = 0;
	string field_name [8] = '{"phase", "input_peak", "voice_peak", "samples_in_phase",
		"room_square_sum", "room_count", "voice_square_sum", "voice_count"};

	function automatic logic [63:0] sat_add(logic [63:0] a, logic [63:0] b, logic [63:0] lim);
		logic [64:0] s;
		s = a + b;
		return (s > lim) ? lim : s[63:0];
	endfunction

	function automatic level_report_t advance_calibration(logic [1:0] cmd,
			logic signed [SAMPLE_W-1:0] smp, logic last);
		logic [16:0]      mag;
		logic [31:0]      decayed;
		logic [CNT_W-1:0] rc;
		logic [CNT_W-1:0] vc;
		bit               pass;
		level_report_t    r;
		case (cmd)
		CMD_START: begin
			ph_cnt = '0;
			room_e = '0;
			room_n = '0;
			voice_e = '0;
			voice_n = '0;
			spk_peak = '0;
			in_peak_q = '0;
			blk_energy = '0;
			blk_len = 0;
			blk_peak = '0;
			cal_phase = PH_ROOM;
		end
		CMD_CANCEL: begin
			cal_phase = PH_IDLE;
			in_peak_q = '0;
			blk_energy = '0;
			blk_len = 0;
			blk_peak = '0;
		end
		CMD_SAMPLE: begin
			if (cal_phase == PH_ROOM || cal_phase == PH_VOICE) begin
				mag = (smp < 0) ? 17'(-32'(smp)) : 17'(smp);
				blk_energy = 48'(sat_add(64'(blk_energy), 64'(mag) * 64'(mag), BLK_SUM_MAX));
				if (mag > 17'(blk_peak))
					blk_peak = mag[PEAK_W-1:0];
				blk_len++;
				if (last || blk_len >= MAX_BLOCK) begin
					decayed = (32'(in_peak_q) * 32'(DECAY_MUL)) >> DECAY_SHIFT;
					in_peak_q = (32'(blk_peak) > decayed) ? blk_peak : decayed[PEAK_W-1:0];
					if (cal_phase == PH_ROOM) begin
						room_e = SUM_W'(sat_add(64'(room_e), 64'(blk_energy), SUM_MAX));
						room_n = CNT_W'(sat_add(64'(room_n), 64'(blk_len), CNT_MAX));
						ph_cnt = CNT_W'(sat_add(64'(ph_cnt), 64'(blk_len), CNT_MAX));
						if (ph_cnt >= cfg_room_len) begin
							ph_cnt = '0;
							cal_phase = PH_VOICE;
						end
					end else begin
						voice_e = SUM_W'(sat_add(64'(voice_e), 64'(blk_energy), SUM_MAX));
						voice_n = CNT_W'(sat_add(64'(voice_n), 64'(blk_len), CNT_MAX));
						if (blk_peak > spk_peak)
							spk_peak = blk_peak;
						ph_cnt = CNT_W'(sat_add(64'(ph_cnt), 64'(blk_len), CNT_MAX));
						if (ph_cnt >= cfg_voice_len) begin
							rc = (room_n == 0) ? CNT_W'(1) : room_n;
							vc = (voice_n == 0) ? CNT_W'(1) : voice_n;
							pass = (128'(voice_e) >= 128'(cfg_min_pow) * 128'(vc))
								&& (128'(voice_e) >= 128'(cfg_min_floor) * 128'(vc))
								&& (128'(voice_e) * 128'(rc) >= 128'(room_e) * 128'(4) * 128'(vc));
							cal_phase = pass ? PH_DONE : PH_FAIL;
							if (pass)
								runs_complete++;
							else
								runs_failed++;
						end
					end
					blk_energy = '0;
					blk_len = 0;
					blk_peak = '0;
				end
			end
		end
		default: ;
		endcase
		r.phase = cal_phase;
		r.input_peak = in_peak_q;
		r.voice_peak = spk_peak;
		r.phase_cnt = ph_cnt;
		r.room_sum = room_e;
		r.room_cnt = room_n;
		r.voice_sum = voice_e;
		r.voice_cnt = voice_n;
		return r;
	endfunction

	task automatic push_word(logic [1:0] cmd, logic signed [SAMPLE_W-1:0] smp, logic last);
		sample_word_t w;
		w.cmd = cmd;
		w.smp = smp;
		w.last = last;
		word_backlog.push_back(w);
		words_queued++;
	endtask

	function automatic logic signed [SAMPLE_W-1:0] draw_sample(int amp);
		int pick;
		pick = $urandom_range(0, 31);
		if (pick == 0)
			return 16'h8000;
		if (pick == 1)
			return 16'h7FFF;
		if (pick < 4)
			return 16'($urandom);
		return 16'(int'($urandom_range(0, 2 * amp)) - amp);
	endfunction

	function automatic logic [31:0] pick_length();
		case ($urandom_range(0, 11))
		0: return 32'd0;
		1: return 32'd1;
		2: return LEN_MAX;
		default: return $urandom_range(2, LEN_CAP);
		endcase
	endfunction

	function automatic logic [31:0] pick_power();
		case ($urandom_range(0, 9))
		0: return 32'd0;
		1: return POW_MAX;
		default: return $urandom_range(0, 1 << 26);
		endcase
	endfunction

	task automatic queue_blocks(int total, int amp);
		int done_n;
		int len;
		done_n = 0;
		while (done_n < total) begin
			len = $urandom_range(1, 12);
			for (int k = 0; k < len; k++)
				push_word(CMD_SAMPLE, draw_sample(amp), k == len - 1);
			done_n += len;
			if ($urandom_range(0, 29) == 0)
				push_word(CMD_NOP, 16'($urandom), 1'($urandom));
		end
	endtask

	// one start followed by room tone and voice blocks, sometimes cut short
	task automatic queue_calibration(int room_amp, int voice_amp);
		int rt;
		int vt;
		rt = (cfg_room_len > LEN_CAP) ? LEN_CAP :
			((cfg_room_len == 0) ? 1 : int'(cfg_room_len));
		vt = (cfg_voice_len > LEN_CAP) ? LEN_CAP :
			((cfg_voice_len == 0) ? 1 : int'(cfg_voice_len));
		push_word(CMD_START, 16'($urandom), 1'($urandom));
		queue_blocks(rt, room_amp);
		if ($urandom_range(0, 9) == 0) begin
			push_word(CMD_CANCEL, 16'($urandom), 1'($urandom));
			queue_blocks(3, voice_amp);
		end else begin
			queue_blocks(vt, voice_amp);
			repeat ($urandom_range(0, 3))
				push_word(CMD_SAMPLE, draw_sample(voice_amp), 1'($urandom));
		end
	endtask

	task automatic write_reg(reg_idx_t idx, logic [31:0] val);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= ADDR_W'({idx, 2'b00});
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
		REG_ROOM_LEN:  cfg_room_len = val[CNT_W-1:0];
		REG_VOICE_LEN: cfg_voice_len = val[CNT_W-1:0];
		REG_MIN_POW:   cfg_min_pow = val[POW_W-1:0];
		REG_MIN_FLOOR: cfg_min_floor = val[POW_W-1:0];
		default: ;
		endcase
	endtask

	task automatic wait_quiet();
		do
			@(negedge clk);
		while (word_backlog.size() != 0 || item_valid || pending_reports.size() != 0);
		repeat (QUIET_CYCLES) @(posedge clk);
	endtask

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("input_level_calibrator regression: fail");
			$finish;
		end
	end

	always @(posedge clk or negedge arst_n) begin : word_driver
		sample_word_t  w;
		level_report_t r;
		if (!arst_n) begin
			item_valid <= 1'b0;
			command <= CMD_SAMPLE;
			sample <= '0;
			last_in_block <= 1'b0;
			send_wait <= 0;
			words_taken <= 0;
		end else begin
			if (item_valid && !item_stall) begin
				r = advance_calibration(command, sample, last_in_block);
				pending_reports.push_back(r);
				words_taken <= words_taken + 1;
			end
			if (!item_valid || !item_stall) begin
				if (send_wait != 0) begin
					item_valid <= 1'b0;
					send_wait <= send_wait - 1;
				end else if (word_backlog.size() != 0) begin
					w = word_backlog.pop_front();
					item_valid <= 1'b1;
					command <= w.cmd;
					sample <= w.smp;
					last_in_block <= w.last;
					if ($urandom_range(0, 47) == 0)
						send_calm = !send_calm;
					send_wait <= send_calm ? 0 : int'($urandom_range(0, 11));
				end else begin
					item_valid <= 1'b0;
				end
			end
		end
	end

	// one long receiver hold-off so the block backs up into item_stall
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_left <= 0;
			hold_used <= 1'b0;
		end else if (!hold_used && words_taken >= HOLD_AT
				&& word_backlog.size() > HOLD_BACKLOG) begin
			hold_left <= HOLD_LEN;
			hold_used <= 1'b1;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
		end
	end

	always @(posedge clk or negedge arst_n) begin : report_monitor
		int            nxt;
		level_report_t want;
		logic [63:0]   wv [8];
		logic [63:0]   gv [8];
		if (!arst_n) begin
			result_stall <= 1'b0;
			recv_wait = 0;
		end else begin
			nxt = (recv_wait != 0) ? recv_wait - 1 : 0;
			if (result_valid && !result_stall) begin
				reports_seen++;
				if (pending_reports.size() == 0) begin
					mismatches++;
					$display("%0t: unexpected report, phase %0d", $time, phase);
				end else begin
					want = pending_reports.pop_front();
					wv = '{want.phase, want.input_peak, want.voice_peak, want.phase_cnt,
						want.room_sum, want.room_cnt, want.voice_sum, want.voice_cnt};
					gv = '{phase, input_peak, voice_peak, samples_in_phase,
						room_square_sum, room_count, voice_square_sum, voice_count};
					for (int i = 0; i < 8; i++) begin
						if (wv[i] !== gv[i]) begin
							mismatches++;
							$display("%0t: %s expected %0d got %0d", $time,
								field_name[i], wv[i], gv[i]);
						end
					end
				end
				if ($urandom_range(0, 47) == 0)
					recv_calm = !recv_calm;
				nxt = recv_calm ? 0 : int'($urandom_range(0, 11));
			end
			recv_wait = nxt;
			result_stall <= (nxt != 0) || (hold_left != 0);
		end
	end

	initial begin : stimulus
		int room_amp;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		write_reg(REG_ROOM_LEN, 32'd2);
		write_reg(REG_VOICE_LEN, 32'd3);
		write_reg(REG_MIN_POW, 32'd0);
		write_reg(REG_MIN_FLOOR, 32'd0);
		@(negedge clk);
		push_word(CMD_SAMPLE, 16'h7FFF, 1'b1);      // idle, dropped
		push_word(CMD_NOP, 16'h1234, 1'b0);
		push_word(CMD_START, 16'h8000, 1'b1);
		push_word(CMD_SAMPLE, 16'h8000, 1'b0);
		push_word(CMD_SAMPLE, 16'h7FFF, 1'b1);
		push_word(CMD_SAMPLE, 16'h0000, 1'b1);
		push_word(CMD_SAMPLE, 16'hFFFF, 1'b0);
		push_word(CMD_SAMPLE, 16'h0001, 1'b1);      // loud room, so fails
		push_word(CMD_SAMPLE, 16'h0005, 1'b1);
		push_word(CMD_CANCEL, 16'h0000, 1'b0);
		push_word(CMD_NOP, 16'h0000, 1'b1);
		push_word(CMD_START, 16'h0000, 1'b0);
		push_word(CMD_SAMPLE, 16'h0064, 1'b0);
		push_word(CMD_CANCEL, 16'h0000, 1'b1);      // cancel inside a block
		push_word(CMD_SAMPLE, 16'h00C8, 1'b1);
		push_word(CMD_START, 16'h0000, 1'b0);
		push_word(CMD_SAMPLE, -16'sd50, 1'b0);
		push_word(CMD_START, 16'h0000, 1'b0);       // restart while running
		push_word(CMD_SAMPLE, 16'h0000, 1'b1);
		push_word(CMD_SAMPLE, 16'h0000, 1'b1);
		push_word(CMD_SAMPLE, 16'sd20000, 1'b1);
		push_word(CMD_SAMPLE, -16'sd20000, 1'b0);
		push_word(CMD_SAMPLE, 16'sd30000, 1'b1);    // quiet room, so completes
		push_word(CMD_SAMPLE, -16'sd7, 1'b1);
		wait_quiet();

		// zero lengths end each phase at the first block end
		write_reg(REG_ROOM_LEN, 32'd0);
		write_reg(REG_VOICE_LEN, 32'd0);
		write_reg(REG_MIN_POW, POW_MAX);
		write_reg(REG_MIN_FLOOR, POW_MAX);
		@(negedge clk);
		push_word(CMD_START, 16'h0000, 1'b0);
		push_word(CMD_SAMPLE, 16'h8000, 1'b1);
		push_word(CMD_SAMPLE, 16'h8000, 1'b1);
		push_word(CMD_START, 16'h0000, 1'b0);
		push_word(CMD_SAMPLE, 16'h0000, 1'b1);
		push_word(CMD_SAMPLE, 16'h8000, 1'b1);
		wait_quiet();

		for (int seg = 0; seg < 6; seg++) begin : random_batch
			int goal;
			write_reg(REG_ROOM_LEN, (seg == 0) ? LEN_MAX : pick_length());
			write_reg(REG_VOICE_LEN, (seg == 1) ? LEN_MAX : pick_length());
			write_reg(REG_MIN_POW, pick_power());
			write_reg(REG_MIN_FLOOR, pick_power());
			@(negedge clk);
			goal = words_queued + BATCH_WORDS;
			while (words_queued < goal) begin
				room_amp = $urandom_range(0, 3000);
				queue_calibration(room_amp, $urandom_range(0, 32767));
			end
			wait_quiet();
		end

		$display("%0d words taken, %0d reports checked over 8 register settings",
			words_taken, reports_seen);
		$display("voice phases ended: %0d complete, %0d failed", runs_complete, runs_failed);
		if (mismatches == 0 && pending_reports.size() == 0)
			$display("input_level_calibrator regression: pass");
		else
			$display("input_level_calibrator regression: fail");
		$finish;
	end

endmodule
